[hw/rtl/ebp_pkg.sv]
// Shared types, field widths and codes for the edge block probe.
package ebp_pkg;

    localparam int BLOCK_SLOTS_DEF = 8;
    localparam int VERTEX_BITS_DEF = 32;
    localparam int TYPE_BITS_DEF   = 8;

    localparam int CMD_W    = 2;
    localparam int OFFSET_W = 3;
    localparam int VERTEX_W = 32;
    localparam int TYPE_W   = 8;
    localparam int FLAG_W   = 2;
    localparam int WEIGHT_W = 32;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD  = 2'd0,
        CMD_PROBE = 2'd1,
        CMD_READ  = 2'd2,
        CMD_NOP   = 2'd3
    } t_cmd;

    typedef enum logic [FLAG_W-1:0] {
        FLAG_EMPTY   = 2'd0,
        FLAG_VALID   = 2'd1,
        FLAG_DELETED = 2'd2,
        FLAG_FREE    = 2'd3
    } t_flag;

    typedef struct packed {
        logic [CMD_W-1:0]    command;
        logic [OFFSET_W-1:0] entry_offset;
        logic [VERTEX_W-1:0] vertex_id;
        logic [TYPE_W-1:0]   edge_type;
        logic [FLAG_W-1:0]   entry_flag;
        logic [WEIGHT_W-1:0] entry_weight;
        logic                start_from_hash;
        logic                is_insert;
    } t_in_item;

    typedef struct packed {
        logic                found;
        logic                stopped_at_empty;
        logic [OFFSET_W-1:0] hit_offset;
        logic [VERTEX_W-1:0] out_vertex;
        logic [TYPE_W-1:0]   out_type;
        logic [FLAG_W-1:0]   out_flag;
        logic [WEIGHT_W-1:0] out_weight;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_READ,
        ST_SCAN,
        ST_FINISH
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic wr_load;
        logic rd_offset;
        logic rd_ptr;
        logic ans_zero;
        logic ans_read;
        logic ans_hit;
        logic ans_empty;
        logic out_load;
    } t_ctl;

    // Status from the datapath to the controller.
    typedef struct packed {
        t_cmd cmd;
        logic off_ok;
        logic ptr_ok;
        logic slot_hit;
        logic slot_pass;
    } t_sts;

endpackage

[hw/rtl/ebp_ctrl.sv]
// Controller state machine that sequences load, read and probe transactions.
module ebp_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  logic          i_out_stall,
    output logic          o_out_valid,
    input  ebp_pkg::t_sts i_sts,
    output ebp_pkg::t_ctl o_ctl
);
    import ebp_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    t_ctl   ctl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        ctl        = '0;
        n_state    = r_state;
        o_in_stall = 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    ctl.capture = 1'b1;
                    n_state     = ST_EXEC;
                end
            end
            ST_EXEC: begin
                unique case (i_sts.cmd)
                    CMD_LOAD: begin
                        ctl.wr_load  = i_sts.off_ok;
                        ctl.ans_zero = 1'b1;
                        n_state      = ST_FINISH;
                    end
                    CMD_READ: begin
                        if (i_sts.off_ok) begin
                            ctl.rd_offset = 1'b1;
                            n_state       = ST_READ;
                        end else begin
                            ctl.ans_zero = 1'b1;
                            n_state      = ST_FINISH;
                        end
                    end
                    CMD_PROBE: begin
                        if (i_sts.ptr_ok) begin
                            ctl.rd_ptr = 1'b1;
                            n_state    = ST_SCAN;
                        end else begin
                            ctl.ans_zero = 1'b1;
                            n_state      = ST_FINISH;
                        end
                    end
                    CMD_NOP: begin
                        ctl.ans_zero = 1'b1;
                        n_state      = ST_FINISH;
                    end
                endcase
            end
            ST_READ: begin
                ctl.ans_read = 1'b1;
                n_state      = ST_FINISH;
            end
            ST_SCAN: begin
                // The slot just read is judged; a pass fetches the next in range.
                if (i_sts.slot_hit) begin
                    ctl.ans_hit = 1'b1;
                    n_state     = ST_FINISH;
                end else if (i_sts.slot_pass) begin
                    if (i_sts.ptr_ok) begin
                        ctl.rd_ptr = 1'b1;
                    end else begin
                        ctl.ans_zero = 1'b1;
                        n_state      = ST_FINISH;
                    end
                end else begin
                    ctl.ans_empty = 1'b1;
                    n_state       = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (!r_out_valid || !i_out_stall) begin
                    ctl.out_load = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (ctl.out_load) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    assign o_ctl       = ctl;
    assign o_out_valid = r_out_valid;

endmodule

[hw/rtl/ebp_datapath.sv]
// Datapath: slot memory, probe pointer, match logic and result registers.
module ebp_datapath #(
    parameter int BLOCK_SLOTS = ebp_pkg::BLOCK_SLOTS_DEF,
    parameter int VERTEX_BITS = ebp_pkg::VERTEX_BITS_DEF,
    parameter int TYPE_BITS   = ebp_pkg::TYPE_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ebp_pkg::t_in_item  i_in_item,
    input  ebp_pkg::t_ctl      i_ctl,
    output ebp_pkg::t_sts      o_sts,
    output ebp_pkg::t_out_item o_out_item
);
    import ebp_pkg::*;

    localparam int SLOT_W = $clog2(BLOCK_SLOTS);
    localparam int CNT_W  = $clog2(BLOCK_SLOTS + 1);
    localparam int PTR_W  = (CNT_W > OFFSET_W) ? CNT_W : OFFSET_W;

    logic [VERTEX_BITS-1:0] r_mem_vertex [BLOCK_SLOTS];
    logic [TYPE_BITS-1:0]   r_mem_type   [BLOCK_SLOTS];
    logic [FLAG_W-1:0]      r_mem_flag   [BLOCK_SLOTS];
    logic [WEIGHT_W-1:0]    r_mem_weight [BLOCK_SLOTS];
    logic [BLOCK_SLOTS-1:0] r_vld;

    t_in_item               r_item;
    logic [PTR_W-1:0]       r_ptr;
    logic [VERTEX_BITS-1:0] r_rd_vertex;
    logic [TYPE_BITS-1:0]   r_rd_type;
    logic [FLAG_W-1:0]      r_rd_flag;
    logic [WEIGHT_W-1:0]    r_rd_weight;
    logic                   r_rd_vld;
    logic [SLOT_W-1:0]      r_rd_idx;
    t_out_item              r_ans;
    t_out_item              n_ans;
    t_out_item              r_out;

    logic [PTR_W-1:0]       off_ext;
    logic [PTR_W-1:0]       in_off_ext;
    logic [SLOT_W-1:0]      rd_addr;
    logic                   rd_en;
    logic [VERTEX_BITS-1:0] key_vertex;
    logic [TYPE_BITS-1:0]   key_type;
    logic [FLAG_W-1:0]      eff_flag;
    logic                   match;
    logic [FLAG_W-1:0]      upd_flag;
    logic [WEIGHT_W-1:0]    upd_weight;
    logic                   wr_en;
    logic [SLOT_W-1:0]      wr_addr;
    logic [VERTEX_BITS-1:0] wr_vertex;
    logic [TYPE_BITS-1:0]   wr_type;
    logic [FLAG_W-1:0]      wr_flag;
    logic [WEIGHT_W-1:0]    wr_weight;

    assign off_ext    = PTR_W'(r_item.entry_offset);
    assign in_off_ext = PTR_W'(i_in_item.entry_offset);
    assign key_vertex = VERTEX_BITS'(r_item.vertex_id);
    assign key_type   = TYPE_BITS'(r_item.edge_type);

    // Item capture and probe pointer.
    always_ff @(posedge i_clk) begin
        if (i_ctl.capture) begin
            r_item <= i_in_item;
            r_ptr  <= i_in_item.start_from_hash ? in_off_ext : '0;
        end else if (i_ctl.rd_ptr) begin
            r_ptr <= r_ptr + PTR_W'(1);
        end
    end

    assign rd_en   = i_ctl.rd_offset || i_ctl.rd_ptr;
    assign rd_addr = i_ctl.rd_offset ? off_ext[SLOT_W-1:0] : r_ptr[SLOT_W-1:0];

    // Registered read port of the slot memory.
    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_vertex <= r_mem_vertex[rd_addr];
            r_rd_type   <= r_mem_type[rd_addr];
            r_rd_flag   <= r_mem_flag[rd_addr];
            r_rd_weight <= r_mem_weight[rd_addr];
            r_rd_idx    <= rd_addr;
        end
    end

    // A slot never written since reset reads as an empty all-zero slot.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (wr_en) begin
                r_vld[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                r_rd_vld <= r_vld[rd_addr];
            end
        end
    end

    assign eff_flag = r_rd_vld ? r_rd_flag : FLAG_EMPTY;
    assign match    = (r_rd_vertex == key_vertex) && (r_rd_type == key_type);

    always_comb begin
        upd_flag   = r_rd_flag;
        upd_weight = r_rd_weight;
        if (r_item.is_insert) begin
            if (r_rd_weight != '1) begin
                upd_weight = r_rd_weight + WEIGHT_W'(1);
            end
        end else begin
            upd_flag = FLAG_DELETED;
        end
    end

    assign wr_en = i_ctl.wr_load || i_ctl.ans_hit;

    always_comb begin
        if (i_ctl.wr_load) begin
            wr_addr   = off_ext[SLOT_W-1:0];
            wr_vertex = key_vertex;
            wr_type   = key_type;
            wr_flag   = r_item.entry_flag;
            wr_weight = r_item.entry_weight;
        end else begin
            wr_addr   = r_rd_idx;
            wr_vertex = r_rd_vertex;
            wr_type   = r_rd_type;
            wr_flag   = upd_flag;
            wr_weight = upd_weight;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem_vertex[wr_addr] <= wr_vertex;
            r_mem_type[wr_addr]   <= wr_type;
            r_mem_flag[wr_addr]   <= wr_flag;
            r_mem_weight[wr_addr] <= wr_weight;
        end
    end

    // Staged answer, then the output register.
    always_comb begin
        n_ans = r_ans;
        if (i_ctl.ans_zero) begin
            n_ans = '0;
        end else if (i_ctl.ans_empty) begin
            n_ans                  = '0;
            n_ans.stopped_at_empty = 1'b1;
        end else if (i_ctl.ans_read) begin
            n_ans = '0;
            if (r_rd_vld) begin
                n_ans.out_vertex = VERTEX_W'(r_rd_vertex);
                n_ans.out_type   = TYPE_W'(r_rd_type);
                n_ans.out_flag   = r_rd_flag;
                n_ans.out_weight = r_rd_weight;
            end
        end else if (i_ctl.ans_hit) begin
            n_ans.found            = 1'b1;
            n_ans.stopped_at_empty = 1'b0;
            n_ans.hit_offset       = OFFSET_W'(r_rd_idx);
            n_ans.out_vertex       = VERTEX_W'(r_rd_vertex);
            n_ans.out_type         = TYPE_W'(r_rd_type);
            n_ans.out_flag         = upd_flag;
            n_ans.out_weight       = upd_weight;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ans <= n_ans;
        if (i_ctl.out_load) begin
            r_out <= r_ans;
        end
    end

    assign o_sts.cmd       = t_cmd'(r_item.command);
    assign o_sts.off_ok    = off_ext < PTR_W'(BLOCK_SLOTS);
    assign o_sts.ptr_ok    = r_ptr < PTR_W'(BLOCK_SLOTS);
    assign o_sts.slot_hit  = (eff_flag == FLAG_VALID) && match;
    assign o_sts.slot_pass = (eff_flag == FLAG_DELETED) || ((eff_flag == FLAG_VALID) && !match);
    assign o_out_item      = r_out;

endmodule

[hw/rtl/edge_block_probe.sv]
// Top level of the edge block probe: controller, datapath and checks.
//
// One block of BLOCK_SLOTS edge slots searched by linear probing with tombstones.
// Input channel: i_in_valid / o_in_stall with i_in_item; a transaction is taken
// at a clock edge where valid is high and stall is low. Each input transaction
// gives exactly one result on o_out_valid / i_out_stall with o_out_item.
// Commands: load writes one slot, read returns one slot (offset in range), probe
// scans from the start slot toward the end and updates a matching valid slot.
// Timing: the block works on one transaction at a time. After acceptance, a load
// or no-op goes through EXEC and FINISH, a read through EXEC, READ and FINISH,
// and a probe through EXEC, SCAN once per slot visited and FINISH; FINISH loads
// the result into the output register. The next transaction is accepted once the
// controller is back in IDLE. The scan visits one slot per cycle through the
// registered read port of the slot memory.
// If the receiver stalls, the result holds in the output register and the next
// result waits in the datapath until the register frees up; input is stalled.
// Reset (synchronous, active low) empties every slot at once through per-slot
// valid bits and clears the handshake state; no clearing pass is needed.
module edge_block_probe #(
    parameter int BLOCK_SLOTS = ebp_pkg::BLOCK_SLOTS_DEF,
    parameter int VERTEX_BITS = ebp_pkg::VERTEX_BITS_DEF,
    parameter int TYPE_BITS   = ebp_pkg::TYPE_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  ebp_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output ebp_pkg::t_out_item o_out_item
);
    import ebp_pkg::*;

    t_ctl ctl;
    t_sts sts;

    ebp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .i_sts       (sts),
        .o_ctl       (ctl)
    );

    ebp_datapath #(
        .BLOCK_SLOTS (BLOCK_SLOTS),
        .VERTEX_BITS (VERTEX_BITS),
        .TYPE_BITS   (TYPE_BITS)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_item  (i_in_item),
        .i_ctl      (ctl),
        .o_sts      (sts),
        .o_out_item (o_out_item)
    );

`ifndef SYNTHESIS
    // A waiting result is never overwritten by the next one.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.out_load |-> !(o_out_valid && i_out_stall))
        else $error("result register overwritten while stalled");

    // At most one answer source at a time.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({ctl.ans_zero, ctl.ans_read, ctl.ans_hit, ctl.ans_empty}))
        else $error("more than one answer source selected");

    // A new result appears only after the controller loads it.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(ctl.out_load))
        else $error("output valid rose without a result load");

    // After an accepted transaction the input is stalled.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input accepted twice in a row");
`endif

endmodule
